/* sv/ddm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ddm_pkg;

    // operand geometry, fixed by the 63-bit binary operands
    localparam int OPERAND_BITS   = 63;
    localparam int OPERAND_DIGITS = 19;

    typedef logic [3:0] t_digit;

    // bcd conversion cell operations
    typedef logic [1:0] t_bcd_op;
    localparam t_bcd_op BCD_HOLD   = 2'd0;
    localparam t_bcd_op BCD_CLEAR  = 2'd1;
    localparam t_bcd_op BCD_DABBLE = 2'd2;
    localparam t_bcd_op BCD_SHIFT  = 2'd3;

    // product cell operations
    typedef logic [1:0] t_prod_op;
    localparam t_prod_op PROD_HOLD  = 2'd0;
    localparam t_prod_op PROD_LOAD  = 2'd1;
    localparam t_prod_op PROD_MUL   = 2'd2;
    localparam t_prod_op PROD_SHIFT = 2'd3;

    typedef struct packed {
        t_prod_op op;
        t_digit   mul_digit;
    } t_prod_ctl;

    // quotient by ten for values up to 99, reciprocal multiply
    function automatic t_digit div10(input logic [6:0] value);
        logic [14:0] prod;
        prod = 15'(value) * 15'd205;
        return t_digit'(prod >> 11);
    endfunction

endpackage

`default_nettype wire

/* sv/ddm_bcd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ddm_bcd_cell (
    input  wire logic            i_clk,
    input  wire ddm_pkg::t_bcd_op i_op,
    input  wire logic            i_bit,
    input  wire ddm_pkg::t_digit i_upper,
    output logic                 o_bit,
    output ddm_pkg::t_digit      o_digit
);
    import ddm_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit adj;

    // add three before the shift when the digit would overflow past nine
    assign adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_bit   = adj[3];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_op)
            BCD_CLEAR:  n_digit = '0;
            BCD_DABBLE: n_digit = {adj[2:0], i_bit};
            BCD_SHIFT:  n_digit = i_upper;
            default:    n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

/* sv/ddm_prod_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ddm_prod_cell (
    input  wire logic               i_clk,
    input  wire ddm_pkg::t_prod_ctl i_ctl,
    input  wire ddm_pkg::t_digit    i_a_load,
    input  wire ddm_pkg::t_digit    i_a_lower,
    input  wire ddm_pkg::t_digit    i_p_lower,
    input  wire ddm_pkg::t_digit    i_c_lower,
    output ddm_pkg::t_digit         o_a,
    output ddm_pkg::t_digit         o_p,
    output ddm_pkg::t_digit         o_c
);
    import ddm_pkg::*;

    t_digit     r_a, r_p, r_c;
    t_digit     n_a, n_p, n_c;
    logic [7:0] mul;
    logic [6:0] sum;
    t_digit     quo;
    t_digit     rem;

    // digit product plus held digit plus carry from the lower cell, at most 99
    assign mul = 8'(r_a) * 8'(i_ctl.mul_digit);
    assign sum = 7'(mul + 8'(r_p) + 8'(i_c_lower));
    assign quo = div10(sum);
    assign rem = 4'(sum - 7'(quo) * 7'd10);

    assign o_a = r_a;
    assign o_p = r_p;
    assign o_c = r_c;

    always_comb begin
        n_a = r_a;
        n_p = r_p;
        n_c = r_c;
        unique case (i_ctl.op)
            PROD_LOAD: begin
                n_a = i_a_load;
                n_p = '0;
                n_c = '0;
            end
            PROD_MUL: begin
                n_a = i_a_lower;
                n_p = rem;
                n_c = quo;
            end
            PROD_SHIFT: begin
                n_p = i_p_lower;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_p <= n_p;
        r_c <= n_c;
    end

endmodule

`default_nettype wire

/* sv/decimal_digit_multiplier.sv */
`timescale 1ns / 1ps
`default_nettype none

// decimal digit multiplier: takes two 63-bit binary operands and returns their
// product as decimal digits, most significant first, one digit per output item,
// with o_last_digit on the least significant digit; leading zeros are dropped
// and a zero product comes out as the single digit 0. products longer than
// PRODUCT_DIGITS wrap modulo 10^PRODUCT_DIGITS. one item is in work at a time
// and o_ready is high only while idle: the idle state takes the item, then binary
// to bcd conversion (one bit per cycle in two chains of 19 bcd cells), a load
// step, the multiply (one multiplier digit per cycle across the row of product
// cells, carries handed one cell up per cycle), a flush that settles the
// remaining carries, then the product shifted out of the top cell; output
// stalls add to this last part
module decimal_digit_multiplier #(
    parameter int PRODUCT_DIGITS = 38
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [62:0] i_multiplicand,
    input  wire logic [62:0] i_multiplier,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_digit,
    output logic             o_last_digit
);
    import ddm_pkg::*;

    localparam int REM_W = $clog2(PRODUCT_DIGITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [5:0] CONV_LAST = 6'(OPERAND_BITS - 1);
    localparam logic [5:0] MUL_LAST  = 6'(OPERAND_DIGITS - 1);

    // control
    logic [2:0]       r_state, n_state;
    logic [5:0]       r_cnt, n_cnt;
    logic [REM_W-1:0] r_rem, n_rem;
    logic             r_started, n_started;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [62:0] r_a_bin, n_a_bin;
    logic [62:0] r_b_bin, n_b_bin;
    t_digit      r_digit, n_digit;
    logic        r_last, n_last;

    // cell rows
    t_bcd_op   mcand_op, mplier_op;
    t_prod_ctl prod_ctl;
    t_digit    mcand_digit  [OPERAND_DIGITS];
    t_digit    mplier_digit [OPERAND_DIGITS];
    logic      mcand_bit    [OPERAND_DIGITS];
    logic      mplier_bit   [OPERAND_DIGITS];
    t_digit    cell_a       [PRODUCT_DIGITS];
    t_digit    cell_p       [PRODUCT_DIGITS];
    t_digit    cell_c       [PRODUCT_DIGITS];
    logic      any_carry;
    logic      slot_free;
    t_digit    top_digit;

    // double dabble chains, binary fed msb first into the lowest cell
    for (genvar k = 0; k < OPERAND_DIGITS; k++) begin : g_bcd
        ddm_bcd_cell u_mcand (
            .i_clk   (i_clk),
            .i_op    (mcand_op),
            .i_bit   ((k == 0) ? r_a_bin[62] : mcand_bit[(k == 0) ? 0 : k - 1]),
            .i_upper (4'd0),
            .o_bit   (mcand_bit[k]),
            .o_digit (mcand_digit[k])
        );
        // multiplier digits also shift down so digit zero is always next
        ddm_bcd_cell u_mplier (
            .i_clk   (i_clk),
            .i_op    (mplier_op),
            .i_bit   ((k == 0) ? r_b_bin[62] : mplier_bit[(k == 0) ? 0 : k - 1]),
            .i_upper ((k == OPERAND_DIGITS - 1) ? 4'd0
                      : mplier_digit[(k == OPERAND_DIGITS - 1) ? k : k + 1]),
            .o_bit   (mplier_bit[k]),
            .o_digit (mplier_digit[k])
        );
    end

    // product row: cell k holds product digit k, the shifted multiplicand digit
    // and the carry pending into cell k+1; the top cell's carry falls off
    for (genvar k = 0; k < PRODUCT_DIGITS; k++) begin : g_prod
        localparam int LO = (k == 0) ? 0 : k - 1;
        localparam int LD = (k < OPERAND_DIGITS) ? k : 0;
        ddm_prod_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (prod_ctl),
            .i_a_load  ((k < OPERAND_DIGITS) ? mcand_digit[LD] : 4'd0),
            .i_a_lower ((k == 0) ? 4'd0 : cell_a[LO]),
            .i_p_lower ((k == 0) ? 4'd0 : cell_p[LO]),
            .i_c_lower ((k == 0) ? 4'd0 : cell_c[LO]),
            .o_a       (cell_a[k]),
            .o_p       (cell_p[k]),
            .o_c       (cell_c[k])
        );
    end

    always_comb begin
        any_carry = 1'b0;
        for (int k = 0; k < PRODUCT_DIGITS - 1; k++) begin
            any_carry = any_carry | (cell_c[k] != 4'd0);
        end
    end

    assign top_digit = cell_p[PRODUCT_DIGITS - 1];
    assign slot_free = !r_out_valid || i_ready;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_digit      = r_digit;
    assign o_last_digit = r_last;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_ready;
        n_a_bin     = r_a_bin;
        n_b_bin     = r_b_bin;
        n_digit     = r_digit;
        n_last      = r_last;
        mcand_op    = BCD_HOLD;
        mplier_op   = BCD_HOLD;
        prod_ctl    = '{op: PROD_HOLD, mul_digit: 4'd0};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_a_bin   = i_multiplicand;
                    n_b_bin   = i_multiplier;
                    mcand_op  = BCD_CLEAR;
                    mplier_op = BCD_CLEAR;
                    n_cnt     = '0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                mcand_op  = BCD_DABBLE;
                mplier_op = BCD_DABBLE;
                n_a_bin   = {r_a_bin[61:0], 1'b0};
                n_b_bin   = {r_b_bin[61:0], 1'b0};
                n_cnt     = r_cnt + 6'd1;
                if (r_cnt == CONV_LAST) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                prod_ctl.op = PROD_LOAD;
                n_cnt       = '0;
                n_state     = S_MUL;
            end
            S_MUL: begin
                // add multiplicand * 10^i times multiplier digit i
                prod_ctl  = '{op: PROD_MUL, mul_digit: mplier_digit[0]};
                mplier_op = BCD_SHIFT;
                n_cnt     = r_cnt + 6'd1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // ripple the pending carries until none is left
                if (any_carry) begin
                    prod_ctl = '{op: PROD_MUL, mul_digit: 4'd0};
                end else begin
                    n_rem     = REM_W'(PRODUCT_DIGITS);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_started && top_digit == 4'd0 && r_rem != REM_W'(1)) begin
                    // leading zero, skip it
                    prod_ctl.op = PROD_SHIFT;
                    n_rem       = r_rem - REM_W'(1);
                end else if (slot_free) begin
                    prod_ctl.op = PROD_SHIFT;
                    n_rem       = r_rem - REM_W'(1);
                    n_started   = 1'b1;
                    n_out_valid = 1'b1;
                    n_digit     = top_digit;
                    n_last      = (r_rem == REM_W'(1));
                    if (r_rem == REM_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rem       <= n_rem;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_bin <= n_a_bin;
        r_b_bin <= n_b_bin;
        r_digit <= n_digit;
        r_last  <= n_last;
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int PRODUCT_DIGITS = 38;
    localparam int OPERAND_DIGITS = ddm_pkg::OPERAND_DIGITS;
    localparam int RANDOM_ITEMS   = 430;
    localparam int IDLE_LIMIT     = 5000;   // cycles with no item moving on either side
    localparam int TAIL_CYCLES    = 250;    // longer than one full multiply and shift-out
    localparam int HOLD_CYCLES    = 700;    // the one long receiver hold-off
    localparam int HOLD_AFTER     = 600;    // digits seen before that hold-off starts

    localparam logic [62:0] MAX_OPERAND = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] TEN_POW_18  = 63'd1000000000000000000;

    typedef struct packed {
        logic [62:0] multiplicand;
        logic [62:0] multiplier;
        logic        drain;         // hold this item back until every digit is out
    } t_operand_pair;

    typedef struct packed {
        ddm_pkg::t_digit digit;
        logic            last_digit;
    } t_product_digit;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [62:0] i_multiplicand = '0;
    logic [62:0] i_multiplier = '0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_digit;
    logic        o_last_digit;

    t_operand_pair  operand_q[$];
    t_product_digit product_digit_q[$];

    int items_accepted = 0;
    int total_items = 0;
    int digits_seen = 0;
    int failures = 0;
    int idle_cycles = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall shaping
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_phase = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;

    decimal_digit_multiplier #(
        .PRODUCT_DIGITS(PRODUCT_DIGITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit        (o_digit),
        .o_last_digit   (o_last_digit)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // schoolbook decimal product, digits pushed most significant first,
    // wrapping at PRODUCT_DIGITS with leading zeros dropped
    task automatic predict_product_digits(input logic [62:0] a, input logic [62:0] b);
        int unsigned    a_dig [OPERAND_DIGITS];
        int unsigned    b_dig [OPERAND_DIGITS];
        int unsigned    prod [PRODUCT_DIGITS];
        logic [62:0]    ra;
        logic [62:0]    rb;
        int unsigned    carry;
        int unsigned    t;
        int             pos;
        int             top;
        t_product_digit res;
        if (a == '0 || b == '0) begin
            res.digit = 4'd0;
            res.last_digit = 1'b1;
            product_digit_q.push_back(res);
            return;
        end
        ra = a;
        rb = b;
        for (int i = 0; i < OPERAND_DIGITS; i++) begin
            a_dig[i] = int'(ra % 63'd10);
            b_dig[i] = int'(rb % 63'd10);
            ra = ra / 63'd10;
            rb = rb / 63'd10;
        end
        for (int i = 0; i < PRODUCT_DIGITS; i++) begin
            prod[i] = 0;
        end
        for (int i = 0; i < OPERAND_DIGITS; i++) begin
            carry = 0;
            for (int j = 0; j < OPERAND_DIGITS && i + j < PRODUCT_DIGITS; j++) begin
                t = prod[i + j] + b_dig[i] * a_dig[j] + carry;
                prod[i + j] = t % 10;
                carry = t / 10;
            end
            pos = i + OPERAND_DIGITS;
            while (carry != 0 && pos < PRODUCT_DIGITS) begin
                t = prod[pos] + carry;
                prod[pos] = t % 10;
                carry = t / 10;
                pos++;
            end
        end
        top = PRODUCT_DIGITS - 1;
        while (top > 0 && prod[top] == 0) begin
            top--;
        end
        for (int i = top; i >= 0; i--) begin
            res.digit = ddm_pkg::t_digit'(prod[i]);
            res.last_digit = (i == 0);
            product_digit_q.push_back(res);
        end
    endtask

    task automatic add_pair(input logic [62:0] a, input logic [62:0] b, input logic drain);
        t_operand_pair p;
        p.multiplicand = a;
        p.multiplier = b;
        p.drain = drain;
        operand_q.push_back(p);
    endtask

    // operand mix: zeros, tiny values, random bit widths, decimal patterns
    // heavy in nines and zeros for long carry chains, and full 63-bit values
    function automatic logic [62:0] rand_operand();
        int          r;
        int          n;
        int          d;
        logic [63:0] acc;
        logic [63:0] mask;
        r = $urandom_range(0, 99);
        acc = {$urandom, $urandom};
        if (r < 3) begin
            return '0;
        end else if (r < 20) begin
            return 63'($urandom_range(1, 999));
        end else if (r < 45) begin
            mask = (64'd1 << $urandom_range(1, 63)) - 64'd1;
            return 63'(acc & mask);
        end else if (r < 65) begin
            n = $urandom_range(1, OPERAND_DIGITS);
            acc = 64'($urandom_range(1, (n == OPERAND_DIGITS) ? 8 : 9));
            for (int k = 1; k < n; k++) begin
                case ($urandom_range(0, 3))
                    0: d = 0;
                    1: d = 9;
                    default: d = $urandom_range(0, 9);
                endcase
                acc = acc * 64'd10 + 64'(d);
            end
            return 63'(acc);
        end
        return acc[62:0];
    endfunction

    // idle watchdog: counts cycles in which no item moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // driver: predicts each accepted item, then offers the next one in bursts
    always @(posedge i_clk) begin
        t_operand_pair nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_multiplicand <= '0;
            i_multiplier <= '0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_product_digits(i_multiplicand, i_multiplier);
                items_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (operand_q.size() != 0 &&
                             (!operand_q[0].drain || product_digit_q.size() == 0)) begin
                    nxt = operand_q.pop_front();
                    i_multiplicand <= nxt.multiplicand;
                    i_multiplier <= nxt.multiplier;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        // a third of bursts run straight on, the rest leave
                        // gaps short and long so they land on every phase
                        case ($urandom_range(0, 2))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 10);
                            default: gap_left = $urandom_range(20, 250);
                        endcase
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted digit and shapes the receiver stalls
    always @(posedge i_clk) begin
        t_product_digit want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                digits_seen++;
                if (product_digit_q.size() == 0) begin
                    note_failure($sformatf("unexpected digit %0d last %0b",
                                           o_digit, o_last_digit));
                end else begin
                    want = product_digit_q.pop_front();
                    if (o_digit !== want.digit || o_last_digit !== want.last_digit) begin
                        note_failure($sformatf("digit mismatch: expected %0d last %0b, got %0d last %0b",
                                               want.digit, want.last_digit,
                                               o_digit, o_last_digit));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && digits_seen >= HOLD_AFTER) begin
                // long hold-off so the block backs up and drops o_ready
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(32, 300);
                end else begin
                    rx_mode_left--;
                end
                rx_phase = (rx_phase + 1) % 5;
                case (rx_mode)
                    RX_ALWAYS:   i_ready <= 1'b1;
                    RX_COIN:     i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   i_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: i_ready <= (rx_phase != 0);
                endcase
            end
        end
    end

    initial begin
        // directed: zero operands, ones, extremes, carry chains, trailing zeros
        add_pair('0, '0, 1'b0);
        add_pair('0, MAX_OPERAND, 1'b0);
        add_pair(MAX_OPERAND, '0, 1'b0);
        add_pair(63'd1, 63'd1, 1'b0);
        add_pair(MAX_OPERAND, MAX_OPERAND, 1'b0);
        add_pair(63'd1, MAX_OPERAND, 1'b0);
        add_pair(MAX_OPERAND, 63'd1, 1'b0);
        add_pair(63'd9, 63'd9, 1'b0);
        add_pair(63'd5, 63'd2, 1'b0);
        add_pair(63'd1, 63'd7, 1'b0);
        add_pair(63'd99, 63'd99, 1'b0);
        add_pair(TEN_POW_18, TEN_POW_18, 1'b0);
        add_pair(TEN_POW_18 - 63'd1, TEN_POW_18 - 63'd1, 1'b0);
        add_pair(63'd9000000000000000000, 63'd9000000000000000000, 1'b0);
        add_pair(63'd1, TEN_POW_18, 1'b0);
        add_pair(63'd123456789, 63'd987654321, 1'b0);
        add_pair({32'h5555_5555, 31'h5555_5555}, {32'h2AAA_AAAA, 31'h2AAA_AAAA}, 1'b0);
        add_pair({32'h2AAA_AAAA, 31'h2AAA_AAAA}, {32'h5555_5555, 31'h5555_5555}, 1'b0);
        add_pair(MAX_OPERAND, TEN_POW_18 - 63'd1, 1'b0);
        // random part, with two points where the sender waits for a full drain
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            add_pair(rand_operand(), rand_operand(), (k == 0) || (k == RANDOM_ITEMS / 2));
        end
        total_items = operand_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(items_accepted == total_items && product_digit_q.size() == 0) &&
               idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("decimal_digit_multiplier regression: fail");
            $finish;
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (product_digit_q.size() != 0) begin
                note_failure($sformatf("%0d digits never arrived", product_digit_q.size()));
            end
            if (failures == 0) begin
                $display("decimal_digit_multiplier regression: pass");
            end else begin
                $display("decimal_digit_multiplier regression: fail");
            end
            $finish;
        end
    end

endmodule

/* filelist.f */
sv/ddm_pkg.sv
sv/ddm_bcd_cell.sv
sv/ddm_prod_cell.sv
sv/decimal_digit_multiplier.sv
sim/tb.sv
